// File: sv/bmc_pkg.sv
`default_nettype none

package bmc_pkg;

  // Field widths of the streams and the configuration port.
  localparam int GAIN_W    = 32;
  localparam int ANG_W     = 17;
  localparam int RATE_W    = 16;
  localparam int WHL_W     = 12;
  localparam int DRV_W     = 16;
  localparam int IN_W      = 96;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Internal datapath widths.
  localparam int ACC_W  = 60;         // product accumulator, holds two summed products
  localparam int MQ_W   = 26;         // multiplier operand shift register
  localparam int NB_W   = 5;          // multiplier bit count
  localparam int TERM_W = 42;         // a scaled term clamped to +-2^40
  localparam int FS_W   = 26;         // filtered speed, 8 fraction bits
  localparam int SI_W   = 20;         // speed integral, 8 fraction bits
  localparam int DVD_W  = 28;         // magnitude of the filter sum
  localparam int DVS_W  = DVD_W + 1;  // signed filter sum

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_PROP    = 3'd0,
    REG_UP_RATE    = 3'd1,
    REG_BAL_OFFSET = 3'd2,
    REG_SPD_PROP   = 3'd3,
    REG_SPD_INTEG  = 3'd4,
    REG_STR_PROP   = 3'd5,
    REG_STR_DAMP   = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SUM,
    S_DVD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FS,
    S_SI,
    S_UP_P,
    S_UP_PW,
    S_UP_D,
    S_UP_DW,
    S_UP_SC,
    S_VEL_P,
    S_VEL_PW,
    S_VEL_I,
    S_VEL_IW,
    S_VEL_SC,
    S_ST,
    S_STW,
    S_ST_SC,
    S_BAL,
    S_DRIVE
  } state_t;

  // Command to the serial multiply-accumulate unit.
  typedef struct packed {
    logic                     load;
    logic                     clear;
    logic signed [ACC_W-1:0]  mcand;
    logic signed [MQ_W-1:0]   mplier;
    logic [NB_W-1:0]          nbits;
  } mac_cmd_t;

  localparam logic signed [GAIN_W-1:0] RST_UP_PROP   = -32'sd11796480;
  localparam logic signed [GAIN_W-1:0] RST_UP_RATE   = -32'sd30147;
  localparam logic signed [ANG_W-1:0]  RST_OFFSET    = -17'sd1075;
  localparam logic signed [GAIN_W-1:0] RST_SPD_PROP  = 32'sd373555;
  localparam logic signed [GAIN_W-1:0] RST_SPD_INTEG = 32'sd1901;
  localparam logic signed [GAIN_W-1:0] RST_STR_PROP  = 32'sd0;
  localparam logic signed [GAIN_W-1:0] RST_STR_DAMP  = 32'sd0;

  localparam logic signed [SI_W-1:0]  SI_LIMIT      = 20'sd307200;
  localparam logic signed [ANG_W-1:0] SOFT_TILT     = 17'sd10240;
  localparam logic signed [ANG_W-1:0] NEG_SOFT_TILT = -17'sd10240;
  localparam logic signed [ANG_W-1:0] HARD_TILT     = 17'sd16384;
  localparam logic signed [ANG_W-1:0] NEG_HARD_TILT = -17'sd16384;

  localparam logic signed [ACC_W-1:0] TERM_HI = 60'sh100_0000_0000;
  localparam logic signed [ACC_W-1:0] TERM_LO = -TERM_HI;

  localparam logic [3:0] DIV_BY = 4'd10;

endpackage

`default_nettype wire

// File: sv/bmc_smac.sv
`default_nettype none

// Shift-and-add multiply-accumulate, one multiplier bit per cycle. The
// multiplier is two's complement: its top bit carries negative weight.
module bmc_smac import bmc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  output logic                    busy,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0] mcand;
  logic signed [MQ_W-1:0]  mplier;
  logic [NB_W-1:0]         cnt;
  logic signed [ACC_W-1:0] acc_next;

  assign busy = (cnt != '0);

  always_comb begin
    acc_next = acc;
    if (mplier[0]) begin
      if (cnt == NB_W'(1)) begin
        acc_next = acc - mcand;
      end else begin
        acc_next = acc + mcand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= cmd.nbits;
    end else if (busy) begin
      cnt <= cnt - NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mcand  <= cmd.mcand;
      mplier <= cmd.mplier;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      acc    <= acc_next;
      mcand  <= mcand <<< 1;
      mplier <= mplier >>> 1;
    end
  end

endmodule

`default_nettype wire

// File: sv/bmc_div10.sv
`default_nettype none

// Restoring divide by ten of an unsigned value, one quotient bit per cycle.
module bmc_div10 import bmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] sr;
  logic [3:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic [4:0]       trial;
  logic             fits;

  assign trial    = {rem, sr[DVD_W-1]};
  assign fits     = (trial >= {1'b0, DIV_BY});
  assign busy     = (cnt != '0);
  assign quotient = sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      sr  <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= 4'(trial - {1'b0, DIV_BY});
      end else begin
        rem <= trial[3:0];
      end
      sr <= {sr[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: sv/balance_vehicle_motor_control_unit.sv
// An input transfer's result passes through the speed filter's divide by ten, then the
// bit-serial multiplier for the three product sums, then the drive mix; a held result
// stalls the block until the output register frees.
// One item at a time: the next input transfer is taken once the previous result sits
// in the output register, even if not yet taken.
// Synchronous active-high reset restores register defaults, clears loop state and m_tvalid.
`default_nettype none

module balance_vehicle_motor_control_unit import bmc_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream. s_tdata from bit 0 up: pitch_angle[16:0], pitch_rate[15:0],
  // yaw_rate[15:0], left_wheel_speed[11:0], right_wheel_speed[11:0],
  // steer_command[16:0], zero fill.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,
  // Result stream. m_tdata from bit 0 up: left_drive[15:0], right_drive[15:0].
  // m_tuser: tilt_cutoff.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tuser,
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  // Products carry GAIN_FRACTION_BITS from the gain and 8 from the angle, so
  // every term is scaled down by that sum with rounding toward zero.
  localparam int SHIFT = GAIN_FRACTION_BITS + 8;
  localparam logic [ACC_W-1:0] ROUND_BIAS = {{(ACC_W-SHIFT){1'b0}}, {SHIFT{1'b1}}};

  // Configuration registers.
  logic signed [GAIN_W-1:0] up_prop;
  logic signed [GAIN_W-1:0] up_rate;
  logic signed [ANG_W-1:0]  bal_offset;
  logic signed [GAIN_W-1:0] spd_prop;
  logic signed [GAIN_W-1:0] spd_integ;
  logic signed [GAIN_W-1:0] str_prop;
  logic signed [GAIN_W-1:0] str_damp;

  // Loop state.
  logic signed [FS_W-1:0] fs;
  logic signed [SI_W-1:0] si;

  // Item fields held for the length of the computation.
  logic signed [ANG_W-1:0]  pitch;
  logic signed [RATE_W-1:0] prate;
  logic signed [RATE_W-1:0] yaw;
  logic signed [WHL_W-1:0]  lw;
  logic signed [WHL_W-1:0]  rw;
  logic signed [ANG_W-1:0]  steer;

  // Intermediate results.
  logic signed [DVS_W-1:0]  t7;
  logic signed [DVS_W-1:0]  s768;
  logic signed [DVS_W-1:0]  dvd;
  logic signed [TERM_W-1:0] up_t;
  logic signed [TERM_W-1:0] vel_t;
  logic signed [TERM_W-1:0] st_t;
  logic signed [DRV_W-1:0]  bal;

  state_t state, state_next;

  mac_cmd_t                mac_cmd;
  logic                    mac_busy;
  logic signed [ACC_W-1:0] mac_acc;

  logic             div_start;
  logic             div_busy;
  logic [DVD_W-1:0] div_mag;
  logic [DVD_W-1:0] div_q;

  logic                    out_free;
  logic signed [ANG_W:0]   err;
  logic signed [WHL_W:0]   w_sum;
  logic signed [FS_W-1:0]  q_signed;
  logic signed [FS_W:0]    si_sum;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] acc_shr;
  logic signed [TERM_W-1:0] term;
  logic signed [TERM_W:0]  bal_sum;
  logic signed [TERM_W:0]  l_sum;
  logic signed [TERM_W:0]  r_sum;
  logic                    cut;
  logic                    lean_clear;

  function automatic logic signed [DRV_W-1:0] sat_drive(input logic signed [TERM_W:0] x);
    logic signed [TERM_W:0] hi;
    logic signed [TERM_W:0] lo;
    hi = (TERM_W+1)'(32767);
    lo = -(TERM_W+1)'(32768);
    if (x > hi) begin
      sat_drive = DRV_W'(hi);
    end else if (x < lo) begin
      sat_drive = DRV_W'(lo);
    end else begin
      sat_drive = DRV_W'(x);
    end
  endfunction

  // The configuration port is always open; the user must write only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_prop    <= RST_UP_PROP;
      up_rate    <= RST_UP_RATE;
      bal_offset <= RST_OFFSET;
      spd_prop   <= RST_SPD_PROP;
      spd_integ  <= RST_SPD_INTEG;
      str_prop   <= RST_STR_PROP;
      str_damp   <= RST_STR_DAMP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UP_PROP:    up_prop    <= cfg_data;
        REG_UP_RATE:    up_rate    <= cfg_data;
        REG_BAL_OFFSET: bal_offset <= cfg_data[ANG_W-1:0];
        REG_SPD_PROP:   spd_prop   <= cfg_data;
        REG_SPD_INTEG:  spd_integ  <= cfg_data;
        REG_STR_PROP:   str_prop   <= cfg_data;
        REG_STR_DAMP:   str_damp   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Combinational helpers for the sequencer.
  assign err        = (ANG_W+1)'(pitch) - (ANG_W+1)'(bal_offset);
  assign w_sum      = (WHL_W+1)'(lw) + (WHL_W+1)'(rw);
  assign div_mag    = dvd[DVS_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);
  assign q_signed   = FS_W'(div_q);
  assign si_sum     = (FS_W+1)'(si) + (FS_W+1)'(fs);
  assign cut        = (pitch >= HARD_TILT) || (pitch <= NEG_HARD_TILT);
  assign lean_clear = (pitch > SOFT_TILT) || (pitch < NEG_SOFT_TILT);

  // Scale the accumulated products: round toward zero, then clamp to +-2^40.
  assign acc_rnd = mac_acc + (mac_acc[ACC_W-1] ? ACC_W'(ROUND_BIAS) : ACC_W'(0));
  assign acc_shr = acc_rnd >>> SHIFT;
  always_comb begin
    if (acc_shr > TERM_HI) begin
      term = TERM_W'(TERM_HI);
    end else if (acc_shr < TERM_LO) begin
      term = TERM_W'(TERM_LO);
    end else begin
      term = TERM_W'(acc_shr);
    end
  end

  assign bal_sum = (TERM_W+1)'(up_t) + (TERM_W+1)'(vel_t);
  assign l_sum   = (TERM_W+1)'(bal) + (TERM_W+1)'(st_t);
  assign r_sum   = (TERM_W+1)'(bal) - (TERM_W+1)'(st_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: speed filter and divide first, then the three product sums,
  // each run through the serial multiplier, then the drive mix.
  always_comb begin
    state_next    = state;
    div_start     = 1'b0;
    mac_cmd       = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_SUM;
        end
      end
      S_SUM: state_next = S_DVD;
      S_DVD: state_next = S_DIV_GO;
      S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = S_FS;
        end
      end
      S_FS: state_next = S_SI;
      S_SI: state_next = S_UP_P;
      S_UP_P: begin
        mac_cmd.load   = 1'b1;
        mac_cmd.clear  = 1'b1;
        mac_cmd.mcand  = ACC_W'(up_prop);
        mac_cmd.mplier = MQ_W'(err);
        mac_cmd.nbits  = NB_W'(ANG_W + 1);
        state_next     = S_UP_PW;
      end
      S_UP_PW: begin
        if (!mac_busy) begin
          state_next = S_UP_D;
        end
      end
      S_UP_D: begin
        // The rate term carries no angle fraction, so its gain moves up 8 bits.
        mac_cmd.load   = 1'b1;
        mac_cmd.mcand  = ACC_W'(up_rate) <<< 8;
        mac_cmd.mplier = MQ_W'(prate);
        mac_cmd.nbits  = NB_W'(RATE_W);
        state_next     = S_UP_DW;
      end
      S_UP_DW: begin
        if (!mac_busy) begin
          state_next = S_UP_SC;
        end
      end
      S_UP_SC: state_next = S_VEL_P;
      S_VEL_P: begin
        mac_cmd.load   = 1'b1;
        mac_cmd.clear  = 1'b1;
        mac_cmd.mcand  = ACC_W'(spd_prop);
        mac_cmd.mplier = MQ_W'(fs);
        mac_cmd.nbits  = NB_W'(FS_W);
        state_next     = S_VEL_PW;
      end
      S_VEL_PW: begin
        if (!mac_busy) begin
          state_next = S_VEL_I;
        end
      end
      S_VEL_I: begin
        mac_cmd.load   = 1'b1;
        mac_cmd.mcand  = ACC_W'(spd_integ);
        mac_cmd.mplier = MQ_W'(si);
        mac_cmd.nbits  = NB_W'(SI_W);
        state_next     = S_VEL_IW;
      end
      S_VEL_IW: begin
        if (!mac_busy) begin
          state_next = S_VEL_SC;
        end
      end
      S_VEL_SC: state_next = S_ST;
      S_ST: begin
        mac_cmd.load  = 1'b1;
        mac_cmd.clear = 1'b1;
        if (steer == '0) begin
          // Yaw damping scales by the gain fraction alone; shifting the gain
          // up 8 bits lets it share the common scaling.
          mac_cmd.mcand  = ACC_W'(str_damp) <<< 8;
          mac_cmd.mplier = MQ_W'(yaw);
          mac_cmd.nbits  = NB_W'(RATE_W);
        end else begin
          mac_cmd.mcand  = ACC_W'(str_prop);
          mac_cmd.mplier = MQ_W'(steer);
          mac_cmd.nbits  = NB_W'(ANG_W);
        end
        state_next = S_STW;
      end
      S_STW: begin
        if (!mac_busy) begin
          state_next = S_ST_SC;
        end
      end
      S_ST_SC: state_next = S_BAL;
      S_BAL:   state_next = S_DRIVE;
      S_DRIVE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Loop state and the output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      fs       <= '0;
      si       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_FS) begin
        fs <= dvd[DVS_W-1] ? -q_signed : q_signed;
      end
      if (state == S_SI) begin
        if (si_sum > (FS_W+1)'(SI_LIMIT)) begin
          si <= SI_LIMIT;
        end else if (si_sum < -(FS_W+1)'(SI_LIMIT)) begin
          si <= -SI_LIMIT;
        end else begin
          si <= SI_W'(si_sum);
        end
      end
      // A large tilt empties the integral once this tick's drives are formed.
      if (state == S_DRIVE && out_free && lean_clear) begin
        si <= '0;
      end
      if (state == S_DRIVE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pitch <= s_tdata[16:0];
      prate <= s_tdata[32:17];
      yaw   <= s_tdata[48:33];
      lw    <= s_tdata[60:49];
      rw    <= s_tdata[72:61];
      steer <= s_tdata[89:73];
    end
    if (state == S_SUM) begin
      // 7 * fs and 768 * 10 * (left + right), both with 8 fraction bits.
      t7   <= (DVS_W'(fs) <<< 3) - DVS_W'(fs);
      s768 <= (DVS_W'(w_sum) <<< 13) - (DVS_W'(w_sum) <<< 9);
    end
    if (state == S_DVD) begin
      dvd <= t7 + s768;
    end
    if (state == S_UP_SC) begin
      up_t <= term;
    end
    if (state == S_VEL_SC) begin
      vel_t <= term;
    end
    if (state == S_ST_SC) begin
      st_t <= term;
    end
    if (state == S_BAL) begin
      bal <= sat_drive(bal_sum);
    end
    if (state == S_DRIVE && out_free) begin
      if (cut) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {sat_drive(r_sum), sat_drive(l_sum)};
      end
      m_tuser <= cut;
    end
  end

  bmc_smac u_smac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  bmc_div10 u_div10 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .busy     (div_busy),
    .quotient (div_q)
  );

endmodule

`default_nettype wire

// File: sv/bmc_checker.sv
`default_nettype none

module bmc_checker import bmc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser
);

  // Reset leaves no result pending and the input side open.
  a_reset_state: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result pending or input closed after reset");

  // One item at a time: an input transfer closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  // A new result appears as the block returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result appeared while the block is busy");

  // A tilt cutoff result carries zero drives.
  a_cutoff_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("drives not zero under tilt cutoff");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind balance_vehicle_motor_control_unit bmc_checker u_bmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bmc_pkg::*;

  // Gain format of the block under test. The model below uses the same value.
  localparam int GAIN_FRAC = 16;

  // Scales and limits used to predict the drives.
  localparam longint TERM_SCALE = longint'(1) << (GAIN_FRAC + 8);
  localparam longint DAMP_SCALE = longint'(1) << GAIN_FRAC;
  localparam longint TERM_CAP   = longint'(1) << 40;
  localparam longint INTEG_CAP  = 1200 * 256;
  localparam longint LEAN_LIMIT = 40 * 256;
  localparam longint FALL_LIMIT = 64 * 256;
  localparam longint DRIVE_MAX  = 32767;
  localparam longint DRIVE_MIN  = -32768;

  // There are seven registers; index seven is spare and must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int CYCLE_LIMIT  = 1200000;
  localparam int LONG_HOLD    = 600;
  localparam int PHASE_TICKS  = 170;
  localparam int SETTLE_LEN   = 200;

  // One control tick as it sits on s_tdata, lowest field last.
  typedef struct packed {
    logic [IN_W-91:0]          pad;
    logic signed [ANG_W-1:0]   steer;
    logic signed [WHL_W-1:0]   rw;
    logic signed [WHL_W-1:0]   lw;
    logic signed [RATE_W-1:0]  yaw;
    logic signed [RATE_W-1:0]  prate;
    logic signed [ANG_W-1:0]   pitch;
  } tick_t;

  // One set of motor drives as the block reports it.
  typedef struct {
    logic signed [DRV_W-1:0] left;
    logic signed [DRV_W-1:0] right;
    logic                    cut;
  } drive_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  balance_vehicle_motor_control_unit #(.GAIN_FRACTION_BITS(GAIN_FRAC)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns period: four nanoseconds high, four low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Gain registers as the block should hold them, starting from the reset values.
  longint up_prop  = RST_UP_PROP;
  longint up_rate  = RST_UP_RATE;
  longint lean_off = RST_OFFSET;
  longint spd_prop = RST_SPD_PROP;
  longint spd_int  = RST_SPD_INTEG;
  longint str_prop = RST_STR_PROP;
  longint str_damp = RST_STR_DAMP;

  // Speed loop state: low-passed wheel speed and its clamped integral, both
  // carrying eight fraction bits.
  int speed_filt  = 0;
  int speed_integ = 0;

  tick_t  tick_q[$];    // ticks waiting to be offered on the input stream
  drive_t drive_q[$];   // predicted drives, oldest first

  bit in_fire = 1'b0;        // an input transfer happened at the last rising edge
  bit bursty = 1'b1;         // random idling on both streams
  bit long_hold_req = 1'b0;  // asks the receiver for one long hold-off
  int send_gap = 0;
  int stall_left = 0;
  int wheel_trend = 0;

  int mismatches = 0;
  int ticks_in = 0;
  int drives_checked = 0;
  int cut_ticks = 0;
  int steered_ticks = 0;
  int gain_sets = 0;
  int cycle_count = 0;

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mirrors a register write into the predicted gains. Gains take all 32 bits
  // as signed; the balance offset takes only its low 17 bits.
  function automatic void apply_gain_write(logic [CFG_IDX_W-1:0] idx,
                                           logic [GAIN_W-1:0] val);
    case (idx)
      REG_UP_PROP:    up_prop  = longint'($signed(val));
      REG_UP_RATE:    up_rate  = longint'($signed(val));
      REG_BAL_OFFSET: lean_off = longint'($signed(val[ANG_W-1:0]));
      REG_SPD_PROP:   spd_prop = longint'($signed(val));
      REG_SPD_INTEG:  spd_int  = longint'($signed(val));
      REG_STR_PROP:   str_prop = longint'($signed(val));
      REG_STR_DAMP:   str_damp = longint'($signed(val));
      default: ;
    endcase
  endfunction

  // Works out the drives for one tick and advances the speed loop state.
  // Every division truncates toward zero, as signed integer division does.
  function automatic drive_t predict_drives(tick_t t);
    longint pitch, wheel_sum, upright, velocity, steering, base, lft, rgt;
    drive_t d;
    pitch = longint'(t.pitch);
    upright = (up_prop * (pitch - lean_off) + up_rate * longint'(t.prate) * 256)
              / TERM_SCALE;

    wheel_sum = (longint'(t.lw) + longint'(t.rw)) * 10;
    speed_filt = int'((7 * longint'(speed_filt) + 768 * wheel_sum) / 10);
    speed_integ = int'(clip(longint'(speed_integ) + speed_filt, -INTEG_CAP, INTEG_CAP));
    velocity = (spd_prop * speed_filt + spd_int * speed_integ) / TERM_SCALE;
    // Leaning past forty degrees throws the integral away, after it was used.
    if (pitch > LEAN_LIMIT || pitch < -LEAN_LIMIT) speed_integ = 0;

    // With no steer command the yaw rate is damped instead.
    if (t.steer == 0) begin
      steering = (str_damp * longint'(t.yaw)) / DAMP_SCALE;
    end else begin
      steering = (str_prop * longint'(t.steer)) / TERM_SCALE;
    end

    steering = clip(steering, -TERM_CAP, TERM_CAP);
    upright = clip(upright, -TERM_CAP, TERM_CAP);
    velocity = clip(velocity, -TERM_CAP, TERM_CAP);
    base = clip(upright + velocity, DRIVE_MIN, DRIVE_MAX);
    lft = clip(base + steering, DRIVE_MIN, DRIVE_MAX);
    rgt = clip(base - steering, DRIVE_MIN, DRIVE_MAX);

    // At 64 degrees the vehicle has fallen: motors off, state still updated.
    d.cut = (pitch >= FALL_LIMIT || pitch <= -FALL_LIMIT);
    d.left = d.cut ? '0 : DRV_W'(lft);
    d.right = d.cut ? '0 : DRV_W'(rgt);
    return d;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endfunction

  // Monitor: everything is sampled at the rising edge, before the block's
  // registers move, so the order of processes within the step does not matter.
  always @(posedge clk) begin : watch
    drive_t want, got;
    tick_t t;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_gain_write(cfg_index, cfg_data);

      in_fire = s_tvalid && s_tready;
      if (in_fire) begin
        t = tick_t'(s_tdata);
        want = predict_drives(t);
        drive_q.push_back(want);
        ticks_in++;
        if (want.cut) cut_ticks++;
        if (t.steer != 0) steered_ticks++;
      end

      if (m_tvalid && m_tready) begin
        got.left = m_tdata[DRV_W-1:0];
        got.right = m_tdata[2*DRV_W-1:DRV_W];
        got.cut = m_tuser;
        if (drive_q.size() == 0) begin
          flag_mismatch($sformatf("result with no tick outstanding: left %0d right %0d cut %0b",
                                  got.left, got.right, got.cut));
        end else begin
          want = drive_q.pop_front();
          drives_checked++;
          if (got.left !== want.left)
            flag_mismatch($sformatf("left_drive expected %0d, got %0d", want.left, got.left));
          if (got.right !== want.right)
            flag_mismatch($sformatf("right_drive expected %0d, got %0d",
                                    want.right, got.right));
          if (got.cut !== want.cut)
            flag_mismatch($sformatf("tilt_cutoff expected %0b, got %0b", want.cut, got.cut));
        end
      end
    end
  end

  // Input driver: presents the next queued tick once the current one has made
  // its transfer, with a random gap after some transfers.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        s_tdata <= tick_q.pop_front();
        s_tvalid <= 1'b1;
        if (bursty && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, and on request one long hold-off so the
  // block backs up and stops taking input.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && bursty && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding", drive_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // One register write over the configuration channel.
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Loads a full gain set, plus one write to the spare index that must not
  // disturb anything.
  task automatic set_gains(logic [GAIN_W-1:0] kp_up, logic [GAIN_W-1:0] kd_up,
                           logic [GAIN_W-1:0] offset, logic [GAIN_W-1:0] kp_spd,
                           logic [GAIN_W-1:0] ki_spd, logic [GAIN_W-1:0] kp_str,
                           logic [GAIN_W-1:0] kd_str);
    write_setting(REG_UP_PROP, kp_up);
    write_setting(REG_UP_RATE, kd_up);
    write_setting(REG_SPARE, $urandom);
    write_setting(REG_BAL_OFFSET, offset);
    write_setting(REG_SPD_PROP, kp_spd);
    write_setting(REG_SPD_INTEG, ki_spd);
    write_setting(REG_STR_PROP, kp_str);
    write_setting(REG_STR_DAMP, kd_str);
    gain_sets++;
  endtask

  // Waits until every queued tick has made its transfer and every predicted
  // result has come back, so the block is idle.
  task automatic wait_drained();
    do @(posedge clk); while (tick_q.size() != 0 || s_tvalid || drive_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic void add_tick(int pitch, int prate, int yaw, int lw, int rw, int steer);
    tick_t t;
    t = '0;
    t.pitch = ANG_W'(pitch);
    t.prate = RATE_W'(prate);
    t.yaw = RATE_W'(yaw);
    t.lw = WHL_W'(lw);
    t.rw = WHL_W'(rw);
    t.steer = ANG_W'(steer);
    tick_q.push_back(t);
  endfunction

  // Mostly plausible riding: small lean, wheel speeds that follow a slowly
  // wandering trend so the speed filter and the integral clamp get exercised,
  // now and then a lean near the forty and sixty-four degree limits. The rest
  // is raw noise over the full width of every field.
  function automatic tick_t random_tick();
    tick_t t;
    int lean;
    t = '0;
    if ($urandom_range(0, 9) < 3) begin
      t.pitch = ANG_W'($urandom);
      t.prate = RATE_W'($urandom);
      t.yaw = RATE_W'($urandom);
      t.lw = WHL_W'($urandom);
      t.rw = WHL_W'($urandom);
      t.steer = ANG_W'($urandom);
    end else begin
      if ($urandom_range(0, 24) == 0) wheel_trend = spread(300);
      if ($urandom_range(0, 79) == 0) wheel_trend = $urandom_range(0, 1) ? 2040 : -2040;
      case ($urandom_range(0, 9))
        0:       lean = int'($urandom_range(10200, 10280));
        1:       lean = int'($urandom_range(16340, 16420));
        default: lean = int'($urandom_range(0, 3000));
      endcase
      if ($urandom_range(0, 1) == 1) lean = -lean;
      t.pitch = ANG_W'(lean);
      t.prate = RATE_W'(spread(4000));
      t.yaw = RATE_W'(spread(4000));
      t.lw = WHL_W'(clip(wheel_trend + spread(12), -2048, 2047));
      t.rw = WHL_W'(clip(wheel_trend + spread(12), -2048, 2047));
      t.steer = ($urandom_range(0, 1) == 1) ? '0 : ANG_W'(spread(8000));
    end
    return t;
  endfunction

  // Stimulus sequence.
  initial begin
    int p;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed ticks on the reset gains: lean limits on both sides, the
    // fallen-over cutoff at exactly 64 degrees, full-scale fields.
    add_tick(0, 0, 0, 0, 0, 0);
    add_tick(16384, 0, 0, 2047, 2047, 0);
    add_tick(-16384, 0, 0, -2048, -2048, 0);
    add_tick(16383, 32767, 0, 0, 0, 0);
    add_tick(-16383, -32768, 0, 0, 0, 0);
    add_tick(10241, 0, 0, 500, 500, 0);
    add_tick(10240, 0, 0, 2047, 2047, 0);
    add_tick(-10241, 0, 0, 100, 100, 0);
    add_tick(65535, 32767, 32767, 2047, 2047, 0);
    add_tick(-65536, -32768, -32768, 2047, -2048, 0);
    wait_drained();

    // Directed ticks with steering enabled: yaw damping with no steer command,
    // the smallest and largest commands, cutoff while steering, and a few
    // ticks at full wheel speed that drive the integral into its clamp.
    set_gains(-11796480, -30147, -1075, 373555, 1901, 500000, -40000);
    add_tick(0, 0, 32767, 0, 0, 0);
    add_tick(0, 0, -32768, 0, 0, 0);
    add_tick(200, 100, 12345, 0, 0, 1);
    add_tick(-200, -100, 12345, 0, 0, -1);
    add_tick(0, 0, 0, 0, 0, 65535);
    add_tick(0, 0, 0, 0, 0, -65536);
    add_tick(3000, 2000, 0, 10, 10, 46080);
    add_tick(16384, 0, 500, 0, 0, -46080);
    add_tick(100, 0, 0, 2047, 2047, 0);
    add_tick(100, 0, 0, 2047, 2047, 0);
    add_tick(100, 0, 0, 2047, 2047, 3000);
    add_tick(-100, 0, 0, -2048, -2048, 0);
    add_tick(-100, 0, 0, -2048, -2048, -3000);
    wait_drained();

    // Random phases, each under its own gain set: moderate random gains,
    // both extremes, raw random words, all zero and the reset defaults.
    for (p = 0; p < 8; p++) begin
      case (p)
        1: set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFE_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: set_gains(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        4: set_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        5: set_gains('0, '0, '0, '0, '0, '0, '0);
        6: set_gains(RST_UP_PROP, RST_UP_RATE, GAIN_W'(RST_OFFSET), RST_SPD_PROP,
                     RST_SPD_INTEG, RST_STR_PROP, RST_STR_DAMP);
        default: set_gains(spread(1 << 23), spread(1 << 20), spread(3000), spread(1 << 16),
                           spread(1 << 14), spread(1 << 20), spread(1 << 18));
      endcase
      if (p == 2) long_hold_req = 1'b1;
      if (p == 7) bursty = 1'b0;
      repeat (PHASE_TICKS) tick_q.push_back(random_tick());
      wait_drained();
    end

    // Wait out the settle period to catch any stray result.
    repeat (SETTLE_LEN) @(posedge clk);
    if (drive_q.size() != 0)
      flag_mismatch($sformatf("%0d predicted results never arrived", drive_q.size()));

    $display("Sent %0d control ticks and checked %0d drive results under %0d gain sets.",
             ticks_in, drives_checked, gain_sets + 1);
    $display("%0d ticks tripped the tilt cutoff and %0d carried a steer command.",
             cut_ticks, steered_ticks);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
